FILE: src/spectrum_bar_peak_hold_macros.svh
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef SPECTRUM_BAR_PEAK_HOLD_MACROS_SVH
`define SPECTRUM_BAR_PEAK_HOLD_MACROS_SVH

// same-cycle implication
`define SBPH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBPH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sbph_pkg.sv
`timescale 1ns / 1ps

package sbph_pkg;

  localparam int BAND_COUNT_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 8;

  localparam logic [7:0] BAR_HOLD_RST  = 8'd14;
  localparam logic [7:0] PEAK_HOLD_RST = 8'd60;
  localparam logic [4:0] BAR_MAX_RST   = 5'd31;

  // floor(x / 25) == (x * SCALE_RECIP) >> SCALE_SHIFT for x < 2^19
  localparam int          SCALE_SHIFT = 24;
  localparam logic [19:0] SCALE_RECIP = 20'd671089;
  localparam int          SCALED_W    = 19;
  localparam int          PROD_W      = 39;
  localparam int          LVL_RAW_W   = PROD_W - SCALE_SHIFT;

  localparam int ROOT_STEPS = 16;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAR_HOLD  = 8'd0,
    CFG_PEAK_HOLD = 8'd1,
    CFG_BAR_MAX   = 8'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] bar_hold;
    logic [7:0] peak_hold;
    logic [4:0] bar_max;
  } cfg_t;

  typedef struct packed {
    logic [5:0] band;
    logic [4:0] level;
  } band_item_t;

  typedef struct packed {
    logic [4:0] bar;
    logic [7:0] bar_cnt;
    logic [5:0] peak;
    logic [7:0] peak_cnt;
  } band_state_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ_RE,
    F_SQ_IM,
    F_ROOT,
    F_PICK,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } back_state_e;

endpackage

FILE: src/sbph_if.sv
`timescale 1ns / 1ps

interface sbph_bin_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_part;
  logic signed [15:0] imag_part;
  logic        [6:0]  bin_index;

  modport source (output valid, output real_part, output imag_part, output bin_index,
                  input ready);
  modport sink (input valid, input real_part, input imag_part, input bin_index,
                output ready);
endinterface

interface sbph_band_if;
  logic       valid;
  logic       ready;
  logic [5:0] band_index;
  logic [4:0] bar_level;
  logic [5:0] peak_level;

  modport source (output valid, output band_index, output bar_level, output peak_level,
                  input ready);
  modport sink (input valid, input band_index, input bar_level, input peak_level,
                output ready);
endinterface

interface sbph_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbph_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/sbph_ram.sv
`timescale 1ns / 1ps

module sbph_ram #(
  parameter int WIDTH = $bits(sbph_pkg::band_state_t),
  parameter int DEPTH = sbph_pkg::BAND_COUNT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sbph_queue.sv
`timescale 1ns / 1ps

`include "spectrum_bar_peak_hold_macros.svh"

module sbph_queue #(
  parameter int DEPTH = sbph_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sbph_pkg::band_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output sbph_pkg::band_item_t item_o,
  output logic                 empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sbph_pkg::band_item_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

  `SBPH_ASSERT_IMP(a_queue_no_overflow, push_i, !full_o, "item pushed into a full queue")

endmodule

FILE: src/sbph_front.sv
`timescale 1ns / 1ps

`include "spectrum_bar_peak_hold_macros.svh"

module sbph_front #(
  parameter int BAND_COUNT = sbph_pkg::BAND_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sbph_bin_if.sink             bin_i,
  input  sbph_pkg::cfg_t       cfg_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output sbph_pkg::band_item_t q_item_o
);

  sbph_pkg::front_state_e state_q, state_d;

  logic [15:0]                     re_q, re_d;
  logic [15:0]                     im_q, im_d;
  logic [6:0]                      bin_q, bin_d;
  logic [31:0]                     rad_q, rad_d;
  logic [31:0]                     root_q, root_d;
  logic [sbph_pkg::STEP_W-1:0]     step_q, step_d;
  logic [sbph_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [15:0]                     even_mag_q, even_mag_d;

  logic [15:0]                     sq_op;
  logic [31:0]                     sq;
  logic [31:0]                     bit_w;
  logic [31:0]                     trial;
  logic [15:0]                     mag;
  logic [5:0]                      band;
  logic [15:0]                     other;
  logic [16:0]                     pair_sum;
  logic [sbph_pkg::SCALED_W-1:0]   scaled;
  logic [sbph_pkg::LVL_RAW_W-1:0]  lvl_raw;
  logic [4:0]                      level;

  always_comb begin
    sq_op    = (state_q == sbph_pkg::F_SQ_RE) ? re_q : im_q;
    sq       = 32'(sq_op) * 32'(sq_op);
    bit_w    = 32'd1 << {step_q, 1'b0};
    trial    = root_q + bit_w;
    mag      = root_q[15:0];
    band     = bin_q[6:1];
    other    = (band == 6'd0) ? mag : even_mag_q;
    pair_sum = {1'b0, other} + {1'b0, mag};
    scaled   = {pair_sum[16:1], 3'b000};
    lvl_raw  = prod_q[sbph_pkg::PROD_W-1:sbph_pkg::SCALE_SHIFT];
    level    = (lvl_raw > sbph_pkg::LVL_RAW_W'(cfg_i.bar_max)) ? cfg_i.bar_max
                                                               : lvl_raw[4:0];
  end

  always_comb begin
    state_d    = state_q;
    re_d       = re_q;
    im_d       = im_q;
    bin_d      = bin_q;
    rad_d      = rad_q;
    root_d     = root_q;
    step_d     = step_q;
    prod_d     = prod_q;
    even_mag_d = even_mag_q;
    bin_i.ready = 1'b0;
    q_push_o    = 1'b0;
    q_item_o.band  = band;
    q_item_o.level = level;
    unique case (state_q)
      sbph_pkg::F_IDLE: begin
        bin_i.ready = 1'b1;
        if (bin_i.valid) begin
          re_d    = bin_i.real_part[15] ? 16'(-bin_i.real_part) : bin_i.real_part;
          im_d    = bin_i.imag_part[15] ? 16'(-bin_i.imag_part) : bin_i.imag_part;
          bin_d   = bin_i.bin_index;
          state_d = sbph_pkg::F_SQ_RE;
        end
      end
      sbph_pkg::F_SQ_RE: begin
        rad_d   = sq;
        state_d = sbph_pkg::F_SQ_IM;
      end
      sbph_pkg::F_SQ_IM: begin
        rad_d   = rad_q + sq;
        root_d  = '0;
        step_d  = sbph_pkg::STEP_W'(sbph_pkg::ROOT_STEPS - 1);
        state_d = sbph_pkg::F_ROOT;
      end
      sbph_pkg::F_ROOT: begin
        if (rad_q >= trial) begin
          rad_d  = rad_q - trial;
          root_d = (root_q >> 1) + bit_w;
        end else begin
          root_d = root_q >> 1;
        end
        step_d = step_q - sbph_pkg::STEP_W'(1);
        if (step_q == '0) begin
          state_d = sbph_pkg::F_PICK;
        end
      end
      sbph_pkg::F_PICK: begin
        if (!bin_q[0]) begin
          even_mag_d = mag;
          state_d    = sbph_pkg::F_IDLE;
        end else if (int'(band) >= BAND_COUNT) begin
          state_d = sbph_pkg::F_IDLE;
        end else begin
          prod_d  = sbph_pkg::PROD_W'(scaled) * sbph_pkg::PROD_W'(sbph_pkg::SCALE_RECIP);
          state_d = sbph_pkg::F_PUSH;
        end
      end
      sbph_pkg::F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = sbph_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = sbph_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sbph_pkg::F_IDLE;
      even_mag_q <= '0;
    end else begin
      state_q    <= state_d;
      even_mag_q <= even_mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q   <= re_d;
    im_q   <= im_d;
    bin_q  <= bin_d;
    rad_q  <= rad_d;
    root_q <= root_d;
    step_q <= step_d;
    prod_q <= prod_d;
  end

  `SBPH_ASSERT_IMP(a_push_odd_only, q_push_o, bin_q[0] && (state_q == sbph_pkg::F_PUSH), "push from an even bin")
  `SBPH_ASSERT_IMP(a_root_fits, state_q == sbph_pkg::F_PICK, root_q[31:16] == 16'd0, "magnitude wider than 16 bits")

endmodule

FILE: src/sbph_back.sv
`timescale 1ns / 1ps

`include "spectrum_bar_peak_hold_macros.svh"

module sbph_back #(
  parameter int BAND_COUNT = sbph_pkg::BAND_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbph_pkg::cfg_t       cfg_i,
  input  logic                 q_empty_i,
  input  sbph_pkg::band_item_t q_item_i,
  output logic                 q_pop_o,
  sbph_band_if.source          band_o
);

  localparam int AW = $clog2(BAND_COUNT);

  sbph_pkg::back_state_e state_q, state_d;

  sbph_pkg::band_item_t  item_q, item_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [BAND_COUNT-1:0] valid_q, valid_d;
  logic [4:0]            res_bar_q, res_bar_d;
  logic [5:0]            res_peak_q, res_peak_d;
  logic                  out_valid_q, out_valid_d;
  logic [5:0]            out_band_q, out_band_d;
  logic [4:0]            out_bar_q, out_bar_d;
  logic [5:0]            out_peak_q, out_peak_d;

  sbph_pkg::band_state_t rdata;
  sbph_pkg::band_state_t cur;
  sbph_pkg::band_state_t nxt;
  logic [5:0]            lvl1;
  logic [7:0]            bar_cnt_inc;
  logic [7:0]            peak_cnt_inc;
  logic                  ram_we;

  sbph_ram #(
    .WIDTH ($bits(sbph_pkg::band_state_t)),
    .DEPTH (BAND_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (nxt),
    .raddr_i (AW'(q_item_i.band)),
    .rdata_o (rdata)
  );

  always_comb begin
    cur          = valid_q[addr_q] ? rdata : '0;
    lvl1         = {1'b0, item_q.level} + 6'd1;
    bar_cnt_inc  = (cur.bar_cnt == 8'hFF) ? 8'hFF : cur.bar_cnt + 8'd1;
    peak_cnt_inc = (cur.peak_cnt == 8'hFF) ? 8'hFF : cur.peak_cnt + 8'd1;
    nxt          = cur;
    if (cur.bar < item_q.level) begin
      nxt.bar     = item_q.level;
      nxt.bar_cnt = '0;
    end else if (cur.bar > item_q.level) begin
      nxt.bar_cnt = bar_cnt_inc;
      if (bar_cnt_inc >= cfg_i.bar_hold) begin
        nxt.bar = cur.bar - 5'd1;
      end
    end
    if (cur.peak < lvl1) begin
      nxt.peak     = lvl1;
      nxt.peak_cnt = '0;
    end else begin
      nxt.peak_cnt = peak_cnt_inc;
      if (peak_cnt_inc >= cfg_i.peak_hold) begin
        nxt.peak = cur.peak - 6'd1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    addr_d      = addr_q;
    valid_d     = valid_q;
    res_bar_d   = res_bar_q;
    res_peak_d  = res_peak_q;
    out_valid_d = out_valid_q && !band_o.ready;
    out_band_d  = out_band_q;
    out_bar_d   = out_bar_q;
    out_peak_d  = out_peak_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    unique case (state_q)
      sbph_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          addr_d  = AW'(q_item_i.band);
          state_d = sbph_pkg::B_READ;
        end
      end
      sbph_pkg::B_READ: begin
        ram_we          = 1'b1;
        valid_d[addr_q] = 1'b1;
        res_bar_d       = nxt.bar;
        res_peak_d      = nxt.peak;
        state_d         = sbph_pkg::B_SEND;
      end
      sbph_pkg::B_SEND: begin
        if (!out_valid_q || band_o.ready) begin
          out_valid_d = 1'b1;
          out_band_d  = item_q.band;
          out_bar_d   = res_bar_q;
          out_peak_d  = res_peak_q;
          state_d     = sbph_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = sbph_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbph_pkg::B_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    addr_q     <= addr_d;
    res_bar_q  <= res_bar_d;
    res_peak_q <= res_peak_d;
    out_band_q <= out_band_d;
    out_bar_q  <= out_bar_d;
    out_peak_q <= out_peak_d;
  end

  assign band_o.valid      = out_valid_q;
  assign band_o.band_index = out_band_q;
  assign band_o.bar_level  = out_bar_q;
  assign band_o.peak_level = out_peak_q;

  `SBPH_ASSERT_IMP(a_pop_not_empty, q_pop_o, !q_empty_i, "pop from an empty queue")
  `SBPH_ASSERT_IMP(a_peak_in_range, out_valid_q, out_peak_q <= 6'd32, "peak marker above 32")
  `SBPH_ASSERT_NXT(a_read_written, state_q == sbph_pkg::B_READ, valid_q[addr_q], "band not marked")

endmodule

FILE: src/spectrum_bar_peak_hold.sv
// an accepted odd bin passes the front's square, root, pick and push states, the queue, and
// the back's idle, read and send states; the front takes no new bin until it is through with
// the last, set by the 16-step root loop; the back does a read-modify-write of the band table
// reset: asynchronous, active low; registers return to 14, 60 and 31
// the band table reads as zero after reset through per-band valid bits, no clearing pass
`timescale 1ns / 1ps

module spectrum_bar_peak_hold #(
  parameter int BAND_COUNT = sbph_pkg::BAND_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbph_bin_if.sink    bin_i,
  sbph_band_if.source band_o,
  sbph_cfg_if.sink    cfg_i
);

  sbph_pkg::cfg_t       cfg_q, cfg_d;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  sbph_pkg::band_item_t q_wr_item;
  sbph_pkg::band_item_t q_rd_item;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        sbph_pkg::CFG_BAR_HOLD:  cfg_d.bar_hold  = cfg_i.data;
        sbph_pkg::CFG_PEAK_HOLD: cfg_d.peak_hold = cfg_i.data;
        sbph_pkg::CFG_BAR_MAX:   cfg_d.bar_max   = cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bar_hold  <= sbph_pkg::BAR_HOLD_RST;
      cfg_q.peak_hold <= sbph_pkg::PEAK_HOLD_RST;
      cfg_q.bar_max   <= sbph_pkg::BAR_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sbph_front #(
    .BAND_COUNT (BAND_COUNT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bin_i    (bin_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wr_item)
  );

  sbph_queue #(
    .DEPTH (sbph_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  sbph_back #(
    .BAND_COUNT (BAND_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_rd_item),
    .q_pop_o   (q_pop),
    .band_o    (band_o)
  );

endmodule

FILE: test/sbph_band_checker.sv
`timescale 1ns / 1ps

module sbph_band_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbph_bin_if         bin_i,
  sbph_band_if        band_i,
  sbph_cfg_if         cfg_i,
  output int          err_count_o,
  output int          expected_left_o
);
  import sbph_pkg::*;

  localparam int BANDS = BAND_COUNT_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [5:0] band;
    logic [4:0] bar;
    logic [5:0] peak;
  } band_display_t;

  band_display_t pending_bands[$];

  logic [7:0]  bar_hold_q;
  logic [7:0]  peak_hold_q;
  logic [4:0]  bar_max_q;
  logic [15:0] even_mag_q;
  logic [4:0]  bar_q      [BANDS];
  logic [7:0]  bar_cnt_q  [BANDS];
  logic [5:0]  peak_q     [BANDS];
  logic [7:0]  peak_cnt_q [BANDS];
  int          mismatches;

  function automatic logic [15:0] bin_magnitude(logic [15:0] re, logic [15:0] im);
    logic [16:0] ar;
    logic [16:0] ai;
    logic [31:0] power;
    logic [31:0] trial;
    logic [15:0] root;
    int          b;
    ar = re[15] ? (17'h10000 - {1'b0, re}) : {1'b0, re};
    ai = im[15] ? (17'h10000 - {1'b0, im}) : {1'b0, im};
    power = ar * ar + ai * ai;
    root = '0;
    for (b = 15; b >= 0; b--) begin
      trial = {16'b0, root} | (32'd1 << b);
      if (trial * trial <= power) begin
        root = trial[15:0];
      end
    end
    return root;
  endfunction

  // one bin into the band tables; odd bins queue the new display values
  task automatic update_band_display(logic [15:0] re, logic [15:0] im, logic [6:0] idx);
    logic [15:0]   mag;
    logic [15:0]   other;
    int            band;
    int            level;
    band_display_t item;
    mag = bin_magnitude(re, im);
    band = idx >> 1;
    if (!idx[0]) begin
      even_mag_q = mag;
    end else if (band < BANDS) begin
      other = (band == 0) ? mag : even_mag_q;
      level = ((({1'b0, other} + {1'b0, mag}) >> 1) * 8) / 25;
      if (level > bar_max_q) begin
        level = bar_max_q;
      end
      if (bar_q[band] < level) begin
        bar_q[band] = 5'(level);
        bar_cnt_q[band] = '0;
      end else if (bar_q[band] > level) begin
        if (bar_cnt_q[band] != 8'hFF) begin
          bar_cnt_q[band] = bar_cnt_q[band] + 8'd1;
        end
        if (bar_cnt_q[band] >= bar_hold_q) begin
          bar_q[band] = bar_q[band] - 5'd1;
        end
      end
      if (peak_q[band] < level + 1) begin
        peak_q[band] = 6'(level + 1);
        peak_cnt_q[band] = '0;
      end else begin
        if (peak_cnt_q[band] != 8'hFF) begin
          peak_cnt_q[band] = peak_cnt_q[band] + 8'd1;
        end
        if (peak_cnt_q[band] >= peak_hold_q) begin
          peak_q[band] = peak_q[band] - 6'd1;
        end
      end
      item.band = 6'(band);
      item.bar  = bar_q[band];
      item.peak = peak_q[band];
      pending_bands.push_back(item);
    end
  endtask

  task automatic compare_band(band_display_t got);
    band_display_t want;
    if (pending_bands.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("unexpected band item: band %0d bar %0d peak %0d",
                 got.band, got.bar, got.peak);
      end
    end else begin
      want = pending_bands.pop_front();
      if (want.band !== got.band || want.bar !== got.bar || want.peak !== got.peak) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("band mismatch: expected band %0d bar %0d peak %0d, got band %0d bar %0d peak %0d",
                   want.band, want.bar, want.peak, got.band, got.bar, got.peak);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_hold_q  = BAR_HOLD_RST;
      peak_hold_q = PEAK_HOLD_RST;
      bar_max_q   = BAR_MAX_RST;
      even_mag_q  = '0;
      for (int b = 0; b < BANDS; b++) begin
        bar_q[b]      = '0;
        bar_cnt_q[b]  = '0;
        peak_q[b]     = '0;
        peak_cnt_q[b] = '0;
      end
      pending_bands.delete();
      mismatches = 0;
      err_count_o <= 0;
      expected_left_o <= 0;
    end else begin
      if (band_i.valid && band_i.ready) begin
        compare_band({band_i.band_index, band_i.bar_level, band_i.peak_level});
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_BAR_HOLD:  bar_hold_q  = cfg_i.data;
          CFG_PEAK_HOLD: peak_hold_q = cfg_i.data;
          CFG_BAR_MAX:   bar_max_q   = cfg_i.data[4:0];
          default: ;
        endcase
      end
      if (bin_i.valid && bin_i.ready) begin
        update_band_display(bin_i.real_part, bin_i.imag_part, bin_i.bin_index);
      end
      err_count_o <= mismatches;
      expected_left_o <= pending_bands.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int         BANDS         = sbph_pkg::BAND_COUNT_DEF;
  localparam int         QUIET_CYCLES  = 60;
  localparam int         LONG_HOLD     = 300;
  localparam int         NO_ACCEPT_MAX = 2000;
  localparam logic [7:0] CFG_UNUSED_LO = 8'd3;
  localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

  logic clk_i;
  logic rst_ni;

  int tx_idle_pct;
  int rx_idle_pct;
  int stall_requests;
  int stall_served;
  int err_count;
  int expected_left;

  sbph_bin_if  bin_if ();
  sbph_band_if band_if ();
  sbph_cfg_if  cfg_if ();

  spectrum_bar_peak_hold dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_if),
    .band_o (band_if),
    .cfg_i  (cfg_if)
  );

  sbph_band_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bin_i           (bin_if),
    .band_i          (band_if),
    .cfg_i           (cfg_if),
    .err_count_o     (err_count),
    .expected_left_o (expected_left)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // band receiver with random stalls and one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    stall_served = 0;
    band_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        band_if.ready <= 1'b0;
      end else begin
        band_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    int no_accept;
    no_accept = 0;
    forever begin
      @(posedge clk_i);
      if ((bin_if.valid && bin_if.ready) || (band_if.valid && band_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        no_accept = 0;
      end else if (rst_ni) begin
        no_accept++;
        if (no_accept >= NO_ACCEPT_MAX) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic send_bin(logic signed [15:0] re, logic signed [15:0] im, logic [6:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      bin_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bin_if.valid     <= 1'b1;
    bin_if.real_part <= re;
    bin_if.imag_part <= im;
    bin_if.bin_index <= idx;
    do @(posedge clk_i); while (!(bin_if.valid && bin_if.ready));
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    bin_if.valid <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain all expected bands, then give even bins time to finish
  task automatic settle();
    bin_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] random_part();
    int mag;
    case ($urandom_range(9))
      0: random_part = 16'($urandom);
      1: random_part = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: begin
        mag = $urandom_range(0, 1 << $urandom_range(1, 7));
        random_part = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      end
    endcase
  endfunction

  // mostly even/odd pairs over a few neighboring bands, repeated like frames
  task automatic run_random(int n);
    int sent;
    int pick;
    int first;
    int width;
    int reps;
    int r;
    int b;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        first = $urandom_range(0, BANDS - 1);
        width = $urandom_range(1, 5);
        reps  = $urandom_range(1, 6);
        for (r = 0; r < reps; r++) begin
          for (b = first; b < first + width && b < BANDS; b++) begin
            send_bin(random_part(), random_part(), 7'(2 * b));
            send_bin(random_part(), random_part(), 7'(2 * b + 1));
            sent += 2;
          end
        end
      end else if (pick < 87) begin
        send_bin(random_part(), random_part(), 7'(2 * $urandom_range(0, BANDS - 1) + 1));
        sent++;
      end else begin
        send_bin(16'($urandom), 16'($urandom), 7'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    tx_idle_pct = 34;
    rx_idle_pct = 45;
    stall_requests = 0;
    rst_ni <= 1'b0;
    bin_if.valid     <= 1'b0;
    bin_if.real_part <= '0;
    bin_if.imag_part <= '0;
    bin_if.bin_index <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // odd bin right after reset uses the cleared even magnitude
    send_bin(3000, -4000, 7'd5);
    // dc bin is ignored, band 0 uses bin 1 twice
    send_bin(-32768, -32768, 7'd0);
    send_bin(30, -40, 7'd1);
    send_bin(-32768, -32768, 7'd1);
    send_bin(32767, 32767, 7'd126);
    send_bin(-32768, 0, 7'd127);
    send_bin(0, 0, 7'd2);
    send_bin(0, 0, 7'd3);
    send_bin(-1, 1, 7'd10);
    send_bin(100, -100, 7'd11);
    send_bin(21845, -21846, 7'd64);
    send_bin(-10923, 10922, 7'd65);
    send_bin(200, 0, 7'd9);
    send_bin(0, 0, 7'd8);
    settle();

    // writes to unused indexes, then clamp to zero with zero hold
    write_reg(CFG_UNUSED_LO, 8'h00);
    write_reg(CFG_UNUSED_HI, 8'hFF);
    write_reg(sbph_pkg::CFG_BAR_MAX, 8'hE0);
    write_reg(sbph_pkg::CFG_BAR_HOLD, 8'd0);
    write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'd0);
    send_bin(500, 500, 7'd9);
    send_bin(500, 500, 7'd9);
    send_bin(-32768, -32768, 7'd127);
    send_bin(7, 7, 7'd1);
    send_bin(100, -100, 7'd11);
    settle();

    write_reg(sbph_pkg::CFG_BAR_HOLD, 8'd2);
    write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'd5);
    write_reg(sbph_pkg::CFG_BAR_MAX, 8'hFF);
    run_random(220);
    settle();

    tx_idle_pct = 45;
    rx_idle_pct = 34;
    write_reg(sbph_pkg::CFG_BAR_HOLD, 8'd1);
    write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'd0);
    write_reg(sbph_pkg::CFG_BAR_MAX, 8'd1);
    run_random(90);
    settle();
    write_reg(sbph_pkg::CFG_BAR_HOLD, 8'd3);
    write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'd2);
    write_reg(sbph_pkg::CFG_BAR_MAX, 8'd20);
    run_random(110);
    settle();

    // longest holds on band 0 until the hold counts saturate,
    // starting under a long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(sbph_pkg::CFG_BAR_HOLD, 8'hFF);
    write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'hFF);
    write_reg(sbph_pkg::CFG_BAR_MAX, 8'd31);
    stall_requests++;
    send_bin(300, 0, 7'd1);
    for (i = 0; i < 262; i++) begin
      send_bin(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 7'd1);
    end
    settle();

    for (i = 0; i < 4; i++) begin
      write_reg(sbph_pkg::CFG_BAR_HOLD, 8'($urandom_range(0, 6)));
      write_reg(sbph_pkg::CFG_PEAK_HOLD, 8'($urandom));
      write_reg(sbph_pkg::CFG_BAR_MAX, 8'($urandom));
      write_reg(8'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 8'($urandom));
      run_random(55);
      settle();
    end

    if (err_count == 0 && expected_left == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/sbph_pkg.sv
src/sbph_if.sv
src/sbph_ram.sv
src/sbph_queue.sv
src/sbph_front.sv
src/sbph_back.sv
src/spectrum_bar_peak_hold.sv
test/sbph_band_checker.sv
test/tb_top.sv
